>>> hdl/tttg_pkg.sv
// Shared constants and codes for the two-channel timed tone generator.
`default_nettype none
package tttg_pkg;

    localparam int NUM_CHANNELS_DEFAULT = 2;

    // Field widths
    localparam int OP_W       = 2;
    localparam int FREQ_W     = 20;
    localparam int DUR_W      = 16;
    localparam int CLK_W      = 24;
    localparam int RELOAD_W   = 24;
    localparam int COMPARE_W  = 23;
    localparam int TIME_W     = 32;
    localparam int PRESENT_W  = 2;

    // Stream packing
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 96;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMER_CLOCK     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_PRESENT = 2'd1;

    localparam logic [CLK_W-1:0]     CLOCK_RESET   = 24'd1000000;
    localparam logic [PRESENT_W-1:0] PRESENT_RESET = 2'b11;
    localparam logic [RELOAD_W-1:0]  MIN_QUOTIENT  = 24'd2;

    // Item operations
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_PLAY    = 2'd1;
    localparam logic [OP_W-1:0] OP_SILENCE = 2'd2;

    // Divider: one quotient bit per step
    localparam int DIV_STEPS   = CLK_W;
    localparam int DIV_COUNT_W = $clog2(DIV_STEPS);

endpackage
`default_nettype wire

>>> hdl/tttg_div.sv
// Iterative restoring divider: timer clock over frequency, one bit per cycle.
`default_nettype none
module tttg_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [tttg_pkg::CLK_W-1:0]  dividend,
    input  wire logic [tttg_pkg::FREQ_W-1:0] divisor,
    output logic                            done,
    output logic [tttg_pkg::CLK_W-1:0]       quotient
);
    import tttg_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_COUNT_W-1:0] count_reg;
    logic [FREQ_W-1:0]      rem_reg;
    logic [FREQ_W-1:0]      divisor_reg;
    logic [CLK_W-1:0]       quot_reg;

    logic [FREQ_W:0]        shifted;
    logic [FREQ_W+1:0]      diff;
    logic                   qbit;
    logic [FREQ_W-1:0]      rem_next;

    // Bring down the next dividend bit and try the subtraction
    always_comb begin
        shifted  = {rem_reg, quot_reg[CLK_W-1]};
        diff     = {1'b0, shifted} - {2'b00, divisor_reg};
        qbit     = ~diff[FREQ_W+1];
        rem_next = qbit ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                count_reg   <= DIV_COUNT_W'(DIV_STEPS - 1);
                rem_reg     <= '0;
                divisor_reg <= divisor;
                quot_reg    <= dividend;
            end else if (busy_reg) begin
                rem_reg  <= rem_next;
                quot_reg <= {quot_reg[CLK_W-2:0], qbit};
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

>>> hdl/two_channel_timed_tone_generator.sv
// Top level of the two-channel timed tone generator.
`default_nettype none
// Buzzer tone controller for two PWM channels. Each input item is a tick
// (advance the millisecond clock and end expired tones), a play (set a
// channel's period reload to max(clock/frequency, 2) - 1 with 50% duty and
// start timing its duration) or a silence (clear all tones). Every item
// returns one result holding both channels' reload, compare and active flag.
// One item is worked at a time and s_tready is low while it is in flight.
// A play with a nonzero frequency for a present channel waits in the divide
// state: the quotient comes from a shared divider that yields one bit per
// cycle. A tick runs an increment, then an expiry check; every other item
// goes from execution straight to report. A next item is accepted while the
// previous result still waits in the output register; its own result waits
// for that register to empty. Configuration writes are always ready and take
// effect at once; write them only while the block is idle.
module two_channel_timed_tone_generator #(
    parameter int NUM_CHANNELS = tttg_pkg::NUM_CHANNELS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input item stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: freq_hz[19:0], duration_ms[35:20], zero padding[39:36]
    input  wire logic [tttg_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: op[1:0], channel[2]
    input  wire logic [tttg_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: reload_a[23:0], compare_a[46:24], active_a[47],
    //          reload_b[71:48], compare_b[94:72], active_b[95]
    output logic [tttg_pkg::M_TDATA_W-1:0]        m_tdata,
    // Configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tttg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [tttg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tttg_pkg::*;

    localparam bit HAS_B = (NUM_CHANNELS > 1);
    localparam int CH_B  = HAS_B ? 1 : 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIVIDE,
        ST_EXPIRE,
        ST_REPORT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [CLK_W-1:0]     timer_clock_reg;
    logic [PRESENT_W-1:0] present_reg;

    // Latched item
    logic [OP_W-1:0]   op_reg;
    logic              ch_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [DUR_W-1:0]  dur_reg;

    // Channel state
    logic [TIME_W-1:0]    now_ms_reg;
    logic [TIME_W-1:0]    start_time_reg    [NUM_CHANNELS];
    logic [DUR_W-1:0]     tone_length_reg   [NUM_CHANNELS];
    logic                 tone_on_reg       [NUM_CHANNELS];
    logic [RELOAD_W-1:0]  period_reload_reg [NUM_CHANNELS];
    logic [COMPARE_W-1:0] duty_compare_reg  [NUM_CHANNELS];

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Divider hookup
    logic                 div_start;
    logic                 div_done;
    logic [CLK_W-1:0]     div_quot;
    logic [RELOAD_W-1:0]  quot_clamped;
    logic [RELOAD_W-1:0]  reload_new;
    logic                 play_present;
    logic [M_TDATA_W-1:0] report_word;
    logic                 out_free;

    function automatic logic chan_present(input int c, input logic [PRESENT_W-1:0] mask);
        logic hit;
        hit = 1'b0;
        if (c < PRESENT_W) begin
            hit = mask[c[0]];
        end
        return hit;
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign play_present = (int'(ch_reg) < NUM_CHANNELS) && present_reg[ch_reg];
    assign div_start    = (state_reg == ST_EXEC) && (op_reg == OP_PLAY)
                          && play_present && (freq_reg != '0);

    tttg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (timer_clock_reg),
        .divisor  (freq_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Raise the quotient to at least two, then drop one for the reload
    always_comb begin
        quot_clamped = (div_quot < MIN_QUOTIENT) ? MIN_QUOTIENT : div_quot;
        reload_new   = quot_clamped - 1'b1;
    end

    // Snapshot of both channels; with NUM_CHANNELS below two, channel b reads zero
    always_comb begin
        report_word = '0;
        report_word[23:0]  = period_reload_reg[0];
        report_word[46:24] = duty_compare_reg[0];
        report_word[47]    = tone_on_reg[0];
        if (HAS_B) begin
            report_word[71:48] = period_reload_reg[CH_B];
            report_word[94:72] = duty_compare_reg[CH_B];
            report_word[95]    = tone_on_reg[CH_B];
        end
    end

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_clock_reg <= CLOCK_RESET;
            present_reg     <= PRESENT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMER_CLOCK:     timer_clock_reg <= cfg_data;
                CFG_CHANNEL_PRESENT: present_reg     <= cfg_data[PRESENT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, channel state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            now_ms_reg   <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                start_time_reg[c]    <= '0;
                tone_length_reg[c]   <= '0;
                tone_on_reg[c]       <= 1'b0;
                period_reload_reg[c] <= '0;
                duty_compare_reg[c]  <= '0;
            end
        end else begin
            // Drop the result once taken; the report state refills it itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_REPORT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser[1:0];
                        ch_reg    <= s_tuser[2];
                        freq_reg  <= s_tdata[19:0];
                        dur_reg   <= s_tdata[35:20];
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC: begin
                    case (op_reg)
                        OP_TICK: begin
                            now_ms_reg <= now_ms_reg + 1'b1;
                            state_reg  <= ST_EXPIRE;
                        end
                        OP_PLAY: begin
                            if (play_present && freq_reg != '0) begin
                                state_reg <= ST_DIVIDE;
                            end else begin
                                if (play_present) begin
                                    // Zero frequency: clear duty, still start timing
                                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                                        if (int'(ch_reg) == c) begin
                                            duty_compare_reg[c] <= '0;
                                            start_time_reg[c]   <= now_ms_reg;
                                            tone_length_reg[c]  <= dur_reg;
                                            tone_on_reg[c]      <= 1'b1;
                                        end
                                    end
                                end
                                state_reg <= ST_REPORT;
                            end
                        end
                        OP_SILENCE: begin
                            for (int c = 0; c < NUM_CHANNELS; c++) begin
                                if (chan_present(c, present_reg)) begin
                                    duty_compare_reg[c] <= '0;
                                end
                                tone_on_reg[c] <= 1'b0;
                            end
                            state_reg <= ST_REPORT;
                        end
                        default: state_reg <= ST_REPORT;
                    endcase
                end

                ST_DIVIDE: begin
                    if (div_done) begin
                        for (int c = 0; c < NUM_CHANNELS; c++) begin
                            if (int'(ch_reg) == c) begin
                                period_reload_reg[c] <= reload_new;
                                duty_compare_reg[c]  <= reload_new[RELOAD_W-1:1];
                                start_time_reg[c]    <= now_ms_reg;
                                tone_length_reg[c]   <= dur_reg;
                                tone_on_reg[c]       <= 1'b1;
                            end
                        end
                        state_reg <= ST_REPORT;
                    end
                end

                ST_EXPIRE: begin
                    // End every timing tone whose elapsed time reached its length
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (tone_on_reg[c] && ((now_ms_reg - start_time_reg[c])
                                >= {{(TIME_W-DUR_W){1'b0}}, tone_length_reg[c]})) begin
                            tone_on_reg[c] <= 1'b0;
                            if (chan_present(c, present_reg)) begin
                                duty_compare_reg[c] <= '0;
                            end
                        end
                    end
                    state_reg <= ST_REPORT;
                end

                ST_REPORT: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_tdata_reg  <= report_word;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

>>> test/two_channel_timed_tone_generator_tb.sv
// Self-checking testbench for the two-channel timed tone generator.
module two_channel_timed_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tttg_pkg::*;

    // The block never uses op code 3; it only reports the state unchanged.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASES          = 6;
    localparam int HOLD_CYCLES     = 300;
    // Longest item is a play with divide; leave some margin.
    localparam int SETTLE_CYCLES   = 40;
    localparam int DIRECTED_ROWS   = 30;

    // One result item, packed so that it maps straight onto m_tdata.
    typedef struct packed {
        logic                 active_b;
        logic [COMPARE_W-1:0] compare_b;
        logic [RELOAD_W-1:0]  reload_b;
        logic                 active_a;
        logic [COMPARE_W-1:0] compare_a;
        logic [RELOAD_W-1:0]  reload_a;
    } tone_result_t;

    localparam tone_result_t ZERO_RESULT = '0;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [OP_W-1:0]        op;
        logic                   ch;
        logic [FREQ_W-1:0]      freq;
        logic [DUR_W-1:0]       dur;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        bit                     pinned;
        tone_result_t           result;
    } row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Travels alongside the offered item: a result typed into the table.
    bit                     pinned        = 1'b0;
    tone_result_t           pinned_result = '0;

    bit gaps_on      = 1'b0;
    bit hold_request = 1'b0;
    int mismatch_count = 0;

    tone_result_t pending_results[$];

    // Predicted block state and configuration.
    logic [CLK_W-1:0]     clock_hz_q;
    logic [PRESENT_W-1:0] present_q;
    logic [TIME_W-1:0]    now_ms_q;
    logic [TIME_W-1:0]    started_q [2];
    logic [DUR_W-1:0]     length_q  [2];
    logic                 sounding_q[2];
    logic [RELOAD_W-1:0]  reload_q  [2];
    logic [COMPARE_W-1:0] compare_q [2];

    // Directed table: extremes, every op and each special case.
    row_t directed_rows [DIRECTED_ROWS] = '{
        // Tick straight after reset: everything reads zero.
        '{ROW_ITEM, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b1, ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b0, 20'd1000, 16'd3, CFG_TIMER_CLOCK, 24'd0, 1'b1,
          '{reload_a: 24'd999, compare_a: 23'd499, active_a: 1'b1, default: '0}},
        // Top frequency: quotient raised to the minimum.
        '{ROW_ITEM, OP_PLAY, 1'b1, 20'hFFFFF, 16'hFFFF, CFG_TIMER_CLOCK, 24'd0, 1'b1,
          '{reload_a: 24'd999, compare_a: 23'd499, active_a: 1'b1,
            reload_b: 24'd1, compare_b: 23'd0, active_b: 1'b1}},
        '{ROW_ITEM, OP_PLAY, 1'b1, 20'd333333, 16'd1, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        // Zero frequency with zero duration.
        '{ROW_ITEM, OP_PLAY, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b0, 20'd1, 16'd2, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_TICK, 1'b1, 20'd7, 16'd9, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        // Reserved op with every field bit set.
        '{ROW_ITEM, OP_RESERVED, 1'b1, 20'hFFFFF, 16'hFFFF, CFG_TIMER_CLOCK, 24'd0, 1'b0,
          ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b1, 20'd500000, 16'hFFFF, CFG_TIMER_CLOCK, 24'd0, 1'b0,
          ZERO_RESULT},
        '{ROW_ITEM, OP_SILENCE, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        // Fastest timer clock against the lowest frequency.
        '{ROW_WRITE, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'hFFFFFF, 1'b0,
          ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b0, 20'd1, 16'd5, CFG_TIMER_CLOCK, 24'd0, 1'b1,
          '{reload_a: 24'd16777214, compare_a: 23'd8388607, active_a: 1'b1,
            reload_b: 24'd1, default: '0}},
        // Slowest timer clock, below the frequency.
        '{ROW_WRITE, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd1000, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b0, 20'hFFFFF, 16'd4, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b1, 20'd3, 16'd1, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        // Channel 1 absent: play ignored, expiry keeps its compare.
        '{ROW_WRITE, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_CHANNEL_PRESENT, 24'd1, 1'b0,
          ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b1, 20'd7, 16'd3, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b0, 20'd10, 16'd9, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_SILENCE, 1'b1, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        // Channel 0 absent.
        '{ROW_WRITE, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_CHANNEL_PRESENT, 24'd2, 1'b0,
          ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b0, 20'd5, 16'd1, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_PLAY, 1'b1, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        // No channel present: silence only drops the active flags.
        '{ROW_WRITE, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_CHANNEL_PRESENT, 24'd0, 1'b0,
          ZERO_RESULT},
        '{ROW_ITEM, OP_SILENCE, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_ITEM, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd0, 1'b0, ZERO_RESULT},
        '{ROW_WRITE, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_CHANNEL_PRESENT, 24'd3, 1'b0,
          ZERO_RESULT},
        '{ROW_WRITE, OP_TICK, 1'b0, 20'd0, 16'd0, CFG_TIMER_CLOCK, 24'd1000000, 1'b0,
          ZERO_RESULT}
    };

    two_channel_timed_tone_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Return the predictor to its reset state.
    task automatic clear_tones();
        clock_hz_q = CLOCK_RESET;
        present_q  = PRESENT_RESET;
        now_ms_q   = '0;
        for (int c = 0; c < 2; c++) begin
            started_q[c]  = '0;
            length_q[c]   = '0;
            sounding_q[c] = 1'b0;
            reload_q[c]   = '0;
            compare_q[c]  = '0;
        end
    endtask

    // Apply one item to the predicted state and return both channels' state.
    task automatic advance_tones(input logic [OP_W-1:0] op, input logic ch,
                                 input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur,
                                 output tone_result_t res);
        logic [RELOAD_W-1:0] quot;
        case (op)
            OP_TICK: begin
                now_ms_q = now_ms_q + 1'b1;
                for (int c = 0; c < 2; c++) begin
                    // Elapsed time wraps modulo 2^32.
                    if (sounding_q[c] && (now_ms_q - started_q[c]) >= {16'd0, length_q[c]}) begin
                        sounding_q[c] = 1'b0;
                        if (present_q[c])
                            compare_q[c] = '0;
                    end
                end
            end
            OP_PLAY: begin
                if (present_q[ch]) begin
                    if (freq == '0) begin
                        compare_q[ch] = '0;
                    end else begin
                        quot = clock_hz_q / {4'd0, freq};
                        if (quot < MIN_QUOTIENT)
                            quot = MIN_QUOTIENT;
                        quot = quot - 1'b1;
                        reload_q[ch]  = quot;
                        compare_q[ch] = quot[RELOAD_W-1:1];
                    end
                    started_q[ch]  = now_ms_q;
                    length_q[ch]   = dur;
                    sounding_q[ch] = 1'b1;
                end
            end
            OP_SILENCE: begin
                for (int c = 0; c < 2; c++) begin
                    if (present_q[c])
                        compare_q[c] = '0;
                    sounding_q[c] = 1'b0;
                end
            end
            default: ;
        endcase
        res.reload_a  = reload_q[0];
        res.compare_a = compare_q[0];
        res.active_a  = sounding_q[0];
        res.reload_b  = reload_q[1];
        res.compare_b = compare_q[1];
        res.active_b  = sounding_q[1];
    endtask

    task automatic check_field(input string label, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // Watch both input channels: track config writes and predict every
    // accepted item. All values here are the ones before the edge.
    always @(posedge aclk) begin : watch_inputs
        tone_result_t predicted;
        if (!aresetn) begin
            clear_tones();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TIMER_CLOCK)
                    clock_hz_q = cfg_data;
                else if (cfg_index == CFG_CHANNEL_PRESENT)
                    present_q = cfg_data[PRESENT_W-1:0];
            end
            if (s_tvalid && s_tready) begin
                advance_tones(s_tuser[1:0], s_tuser[2], s_tdata[19:0], s_tdata[35:20], predicted);
                pending_results.push_back(pinned ? pinned_result : predicted);
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : watch_results
        tone_result_t got;
        tone_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing expected, got %h", $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                check_field("reload_a", want.reload_a, got.reload_a);
                check_field("compare_a", want.compare_a, got.compare_a);
                check_field("active_a", want.active_a, got.active_a);
                check_field("reload_b", want.reload_b, got.reload_b);
                check_field("compare_b", want.compare_b, got.compare_b);
                check_field("active_b", want.active_b, got.active_b);
            end
        end
    end

    // Receiver: idle at random, or hold off for a long, counted stretch
    // when asked so that the block fills up and stalls its input.
    initial begin : drive_ready
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (gaps_on) begin
                m_tready <= ($urandom_range(0, 99) >= 23);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Drop valid and wait until every predicted result has come back.
    // The first edge lets a just-accepted item reach the queue.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one item, after an optional random gap, and hold it until taken.
    task automatic send_item(input logic [OP_W-1:0] op, input logic ch,
                             input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur,
                             input bit pin, input tone_result_t pin_result);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 23) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= {4'd0, dur, freq};
        s_tuser       <= {ch, op};
        pinned        <= pin;
        pinned_result <= pin_result;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Mostly ticks and plays with short tones so that expiry happens often;
    // a few wide frequencies and long durations to toggle every bit.
    task automatic pick_item(output logic [OP_W-1:0] op, output logic ch,
                             output logic [FREQ_W-1:0] freq, output logic [DUR_W-1:0] dur);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            op = OP_TICK;
        else if (roll < 85)
            op = OP_PLAY;
        else if (roll < 95)
            op = OP_SILENCE;
        else
            op = OP_RESERVED;
        ch = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 9);
        if (roll == 0)
            freq = '0;
        else if (roll < 4)
            freq = FREQ_W'($urandom);
        else
            freq = FREQ_W'($urandom_range(1, 5000));
        if ($urandom_range(0, 9) == 0)
            dur = DUR_W'($urandom);
        else
            dur = DUR_W'($urandom_range(0, 12));
    endtask

    initial begin : stimulus
        logic [OP_W-1:0]      op;
        logic                 ch;
        logic [FREQ_W-1:0]    freq;
        logic [DUR_W-1:0]     dur;
        logic [CLK_W-1:0]     clock_pick;
        logic [PRESENT_W-1:0] present_pick;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, full speed on both sides.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
            else
                send_item(directed_rows[r].op, directed_rows[r].ch, directed_rows[r].freq,
                          directed_rows[r].dur, directed_rows[r].pinned,
                          directed_rows[r].result);
        end

        // Random phases, each under its own timer clock and channel mask.
        // Phase 0 runs with no idling at all.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    clock_pick   = CLK_W'($urandom_range(1000, 16777215));
                    present_pick = PRESENT_RESET;
                end
                2: begin
                    clock_pick   = 24'hFFFFFF;
                    present_pick = PRESENT_W'($urandom_range(0, 3));
                end
                3: begin
                    clock_pick   = 24'd1000;
                    present_pick = PRESENT_RESET;
                end
                4: begin
                    clock_pick   = CLK_W'($urandom_range(1000, 100000));
                    present_pick = PRESENT_W'($urandom_range(1, 2));
                end
                5: begin
                    clock_pick   = CLK_W'($urandom_range(1000, 16777215));
                    present_pick = PRESENT_RESET;
                end
                default: begin
                    clock_pick   = CLOCK_RESET;
                    present_pick = PRESENT_RESET;
                end
            endcase
            write_reg(CFG_TIMER_CLOCK, clock_pick);
            write_reg(CFG_CHANNEL_PRESENT, {22'd0, present_pick});
            gaps_on = (phase != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Stall the receiver while items keep coming.
                if (phase == 3 && n == 40)
                    hold_request = 1'b1;
                // Pause the sender until the block has emptied.
                if (phase == 5 && n == 75)
                    wait_drained();
                pick_item(op, ch, freq, dur);
                send_item(op, ch, freq, dur, 1'b0, ZERO_RESULT);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Stop a hung run.
    initial begin : watchdog
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
